### rtl/bmcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmcd_pkg
// Shared types, codes and sizes for the button multi-click detector.
// ----------------------------------------------------------------------------
package bmcd_pkg;

   // sizes
   localparam int NUM_PINS    = 32;
   localparam int DEBOUNCE_MS = 50;
   localparam int MAX_CLICKS  = 5;
   localparam int PIN_IDX_W   = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [15:0] TIME_MAX = 16'hFFFF;
   localparam logic [10:0] DEB_MAX  = 11'h7FF;

   // register indexes
   localparam logic [2:0] CSR_SHORT_GAP     = 3'd0;
   localparam logic [2:0] CSR_LONG_PRESS    = 3'd1;
   localparam logic [2:0] CSR_HOLD_REPEAT   = 3'd2;
   localparam logic [2:0] CSR_CHILD_LOCK    = 3'd3;
   localparam logic [2:0] CSR_INSTANT_TOUCH = 3'd4;

   // button roles
   localparam logic [1:0] ROLE_NORMAL     = 2'd0;
   localparam logic [1:0] ROLE_TOGGLE_ALL = 2'd1;
   localparam logic [1:0] ROLE_SCRIPT     = 2'd2;
   localparam logic [1:0] ROLE_SMART_LED  = 2'd3;

   // channel actions
   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_FIRST  = 2'd1;
   localparam logic [1:0] ACT_SECOND = 2'd2;
   localparam logic [1:0] ACT_ALL    = 2'd3;

   // notices; a burst of n clicks reports NOTICE_CLICK_OFS + n
   localparam logic [3:0] NOTICE_NONE        = 4'd0;
   localparam logic [3:0] NOTICE_PRESS       = 4'd1;
   localparam logic [3:0] NOTICE_RELEASE     = 4'd2;
   localparam logic [3:0] NOTICE_HOLD_START  = 4'd3;
   localparam logic [3:0] NOTICE_HOLD_REPEAT = 4'd4;
   localparam logic [3:0] NOTICE_CLICK_OFS   = 4'd4;

   // stored events; a burst of n clicks stores EVT_CLICK_OFS + n
   localparam logic [3:0] EVT_DOWN      = 4'd0;
   localparam logic [3:0] EVT_UP        = 4'd1;
   localparam logic [3:0] EVT_LONG      = 4'd2;
   localparam logic [3:0] EVT_HOLD      = 4'd3;
   localparam logic [3:0] EVT_CLICK_OFS = 4'd3;
   localparam logic [3:0] EVT_NONE      = 4'd9;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_PRESSED  = 3'd1,
      PH_RELEASED = 3'd2,
      PH_AGAIN    = 3'd3,
      PH_LONG     = 3'd5
   } phase_type;

   typedef struct packed {
      logic [14:0] short_gap_ms;
      logic [14:0] long_press_ms;
      logic [14:0] hold_repeat_ms;
      logic        child_lock;
      logic        instant_touch;
   } cfg_type;

   // queued tick, level already corrected for polarity
   typedef struct packed {
      logic [4:0] pin;
      logic       level;
      logic [1:0] role;
      logic [9:0] dt;
   } q_entry_type;

   typedef struct packed {
      phase_type   phase;
      logic        dlevel;
      logic [10:0] deb_time;
      logic [15:0] phase_time;
      logic [15:0] hold_time;
      logic [2:0]  clicks;
      logic [3:0]  evt;
   } pin_state_type;

   typedef struct packed {
      logic [4:0] pin_echo;
      logic [3:0] notice;
      logic [1:0] channel_action;
      logic [3:0] last_event;
   } rsp_word_type;

   // action for the first toggle of a pin with this role
   function automatic logic [1:0] first_toggle(input logic [1:0] role);
      logic [1:0] act;
      unique case (role)
         ROLE_TOGGLE_ALL: act = ACT_ALL;
         ROLE_SCRIPT:     act = ACT_NONE;
         default:         act = ACT_FIRST;
      endcase
      return act;
   endfunction

endpackage
`default_nettype wire

### rtl/bmcd_chan_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmcd_req_if / bmcd_rsp_if
// Valid/ready channels for tick words in and result words out.
// ----------------------------------------------------------------------------
interface bmcd_req_if;
   logic       valid;
   logic       ready;
   logic [4:0] pin_number;
   logic       raw_level;
   logic       invert_level;
   logic [1:0] button_role;
   logic [9:0] elapsed_ms;

   modport source (output valid, pin_number, raw_level, invert_level, button_role,
                   elapsed_ms, input ready);
   modport sink   (input valid, pin_number, raw_level, invert_level, button_role,
                   elapsed_ms, output ready);
endinterface

interface bmcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] pin_echo;
   logic [3:0] notice;
   logic [1:0] channel_action;
   logic [3:0] last_event;

   modport source (output valid, pin_echo, notice, channel_action, last_event,
                   input ready);
   modport sink   (input valid, pin_echo, notice, channel_action, last_event,
                   output ready);
endinterface
`default_nettype wire

### rtl/bmcd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmcd_front
// Accepts tick words, drops out-of-range pins, folds polarity and queues.
// ----------------------------------------------------------------------------
module bmcd_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   bmcd_req_if.sink                  req_if,
   input  wire logic                 q_pop,
   output logic                      q_valid,
   output bmcd_pkg::q_entry_type     q_data
);

   bmcd_pkg::q_entry_type             q_mem_ff [bmcd_pkg::QDEPTH];
   logic [bmcd_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [bmcd_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [bmcd_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                             in_range;
   logic                             push;
   bmcd_pkg::q_entry_type             entry;

   assign in_range = ({2'b00, req_if.pin_number} < 7'(bmcd_pkg::NUM_PINS));
   assign req_if.ready = (count_ff != bmcd_pkg::QCNT_W'(bmcd_pkg::QDEPTH));
   assign push = req_if.valid && req_if.ready && in_range;

   always_comb begin
      entry.pin   = req_if.pin_number;
      entry.level = req_if.raw_level ^ req_if.invert_level;
      entry.role  = req_if.button_role;
      entry.dt    = req_if.elapsed_ms;
   end

   assign q_valid = (count_ff != '0);
   assign q_data  = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + bmcd_pkg::QCNT_W'(push) - bmcd_pkg::QCNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule
`default_nettype wire

### rtl/bmcd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmcd_back
// Per-pin debounce and phase machine, one read-modify-write per word,
// with a registered result stage.
// ----------------------------------------------------------------------------
module bmcd_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bmcd_pkg::cfg_type    cfg,
   input  wire logic                 q_valid,
   input  wire bmcd_pkg::q_entry_type q_data,
   output logic                      q_pop,
   bmcd_rsp_if.source                rsp_if
);

   bmcd_pkg::pin_state_type          st_ff [bmcd_pkg::NUM_PINS];
   bmcd_pkg::pin_state_type          cur;
   bmcd_pkg::pin_state_type          nxt;
   logic [bmcd_pkg::PIN_IDX_W-1:0]   idx;
   logic                             rsp_valid_ff, rsp_valid_in;
   bmcd_pkg::rsp_word_type           rsp_word_ff;
   bmcd_pkg::rsp_word_type           word;

   logic [16:0] pt_sum;
   logic [15:0] pt1;
   logic [11:0] db_sum;
   logic [16:0] ht_sum;
   logic [15:0] ht1;
   logic        dlevel_n;
   logic [10:0] deb_n;
   logic        pressed;
   logic        lock;
   logic        long_hit;
   logic        reclick;
   logic        burst_end;
   logic        gap_short;
   logic        hold_hit;
   bmcd_pkg::phase_type phase_n;
   logic [3:0]  notice;
   logic [1:0]  action;

   assign idx = q_data.pin[bmcd_pkg::PIN_IDX_W-1:0];
   assign cur = st_ff[idx];
   assign lock = cfg.child_lock;

   // phase time runs while not idle, saturating
   assign pt_sum = {1'b0, cur.phase_time} + 17'(q_data.dt);
   assign pt1 = (cur.phase == bmcd_pkg::PH_IDLE) ? cur.phase_time :
                (pt_sum[16] ? bmcd_pkg::TIME_MAX : pt_sum[15:0]);

   // debounce
   assign db_sum = {1'b0, cur.deb_time} + 12'(q_data.dt);
   always_comb begin
      dlevel_n = cur.dlevel;
      deb_n    = '0;
      if (q_data.level != cur.dlevel) begin
         if (cur.deb_time >= 11'(bmcd_pkg::DEBOUNCE_MS)) begin
            dlevel_n = q_data.level;
         end else begin
            deb_n = db_sum[11] ? bmcd_pkg::DEB_MAX : db_sum[10:0];
         end
      end
   end
   assign pressed = !dlevel_n;

   assign ht_sum = {1'b0, cur.hold_time} + 17'(q_data.dt);
   assign ht1 = ht_sum[16] ? bmcd_pkg::TIME_MAX : ht_sum[15:0];

   assign long_hit  = (pt1 > {1'b0, cfg.long_press_ms});
   assign reclick   = pressed && (cur.clicks < 3'(bmcd_pkg::MAX_CLICKS));
   assign burst_end = (pt1 > {1'b0, cfg.short_gap_ms}) ||
                      (cur.clicks >= 3'(bmcd_pkg::MAX_CLICKS));
   assign gap_short = (pt1 < {1'b0, cfg.short_gap_ms});
   assign hold_hit  = (ht1 > {1'b0, cfg.hold_repeat_ms});

   // next phase
   always_comb begin
      phase_n = cur.phase;
      unique case (cur.phase)
         bmcd_pkg::PH_IDLE: begin
            if (pressed) phase_n = bmcd_pkg::PH_PRESSED;
         end
         bmcd_pkg::PH_PRESSED: begin
            if (!pressed) phase_n = bmcd_pkg::PH_RELEASED;
            else if (long_hit) phase_n = bmcd_pkg::PH_LONG;
         end
         bmcd_pkg::PH_RELEASED: begin
            if (reclick) phase_n = bmcd_pkg::PH_AGAIN;
            else if (burst_end) phase_n = bmcd_pkg::PH_IDLE;
         end
         bmcd_pkg::PH_AGAIN: begin
            if (!pressed) phase_n = gap_short ? bmcd_pkg::PH_RELEASED : bmcd_pkg::PH_IDLE;
         end
         bmcd_pkg::PH_LONG: begin
            if (!pressed) phase_n = bmcd_pkg::PH_IDLE;
         end
         default: begin
            phase_n = cur.phase;
         end
      endcase
   end

   // counters, stored event, notice and action
   always_comb begin
      nxt            = cur;
      nxt.phase      = phase_n;
      nxt.dlevel     = dlevel_n;
      nxt.deb_time   = deb_n;
      nxt.phase_time = pt1;
      notice         = bmcd_pkg::NOTICE_NONE;
      action         = bmcd_pkg::ACT_NONE;
      unique case (cur.phase)
         bmcd_pkg::PH_IDLE: begin
            if (pressed) begin
               nxt.evt        = bmcd_pkg::EVT_DOWN;
               nxt.phase_time = '0;
               nxt.clicks     = 3'd1;
               if (!lock) begin
                  notice = bmcd_pkg::NOTICE_PRESS;
                  if (cfg.instant_touch) action = bmcd_pkg::first_toggle(q_data.role);
               end
            end else begin
               nxt.evt = bmcd_pkg::EVT_NONE;
            end
         end
         bmcd_pkg::PH_PRESSED: begin
            if (!pressed) begin
               nxt.evt        = bmcd_pkg::EVT_UP;
               nxt.phase_time = '0;
               if (!lock) notice = bmcd_pkg::NOTICE_RELEASE;
            end else if (long_hit) begin
               nxt.evt = bmcd_pkg::EVT_LONG;
               if (!lock) notice = bmcd_pkg::NOTICE_HOLD_START;
            end
         end
         bmcd_pkg::PH_RELEASED: begin
            if (reclick) begin
               nxt.evt        = bmcd_pkg::EVT_DOWN;
               nxt.clicks     = cur.clicks + 3'd1;
               nxt.phase_time = '0;
            end else if (burst_end) begin
               nxt.evt = bmcd_pkg::EVT_CLICK_OFS + 4'(cur.clicks);
               if (!lock) begin
                  unique case (cur.clicks)
                     3'd1: begin
                        notice = bmcd_pkg::NOTICE_CLICK_OFS + 4'd1;
                        if (!cfg.instant_touch) action = bmcd_pkg::first_toggle(q_data.role);
                     end
                     3'd2: begin
                        // double click: toggle-all pins act silently
                        if (q_data.role == bmcd_pkg::ROLE_TOGGLE_ALL) begin
                           action = bmcd_pkg::ACT_ALL;
                        end else begin
                           notice = bmcd_pkg::NOTICE_CLICK_OFS + 4'd2;
                           if (q_data.role == bmcd_pkg::ROLE_NORMAL) action = bmcd_pkg::ACT_SECOND;
                        end
                     end
                     default: begin
                        notice = bmcd_pkg::NOTICE_CLICK_OFS + 4'(cur.clicks);
                     end
                  endcase
               end
            end
         end
         bmcd_pkg::PH_AGAIN: begin
            if (!pressed) begin
               nxt.evt = bmcd_pkg::EVT_UP;
               if (!lock) notice = bmcd_pkg::NOTICE_RELEASE;
               if (gap_short) nxt.phase_time = '0;
            end
         end
         bmcd_pkg::PH_LONG: begin
            if (pressed) begin
               nxt.evt       = bmcd_pkg::EVT_HOLD;
               nxt.hold_time = ht1;
               if (hold_hit) begin
                  nxt.hold_time = '0;
                  if (!lock) notice = bmcd_pkg::NOTICE_HOLD_REPEAT;
               end
            end else begin
               nxt.evt = bmcd_pkg::EVT_UP;
               if (!lock) notice = bmcd_pkg::NOTICE_RELEASE;
            end
         end
         default: begin
            nxt.evt = cur.evt;
         end
      endcase
   end

   always_comb begin
      word.pin_echo       = q_data.pin;
      word.notice         = notice;
      word.channel_action = action;
      word.last_event     = nxt.evt;
   end

   assign q_pop = q_valid && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (q_pop) rsp_valid_in = 1'b1;
      else if (rsp_if.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < bmcd_pkg::NUM_PINS; i++) begin
            st_ff[i].phase      <= bmcd_pkg::PH_IDLE;
            st_ff[i].dlevel     <= 1'b1;
            st_ff[i].deb_time   <= '0;
            st_ff[i].phase_time <= '0;
            st_ff[i].hold_time  <= '0;
            st_ff[i].clicks     <= '0;
            st_ff[i].evt        <= bmcd_pkg::EVT_NONE;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) st_ff[idx] <= nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) rsp_word_ff <= word;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.pin_echo       = rsp_word_ff.pin_echo;
   assign rsp_if.notice         = rsp_word_ff.notice;
   assign rsp_if.channel_action = rsp_word_ff.channel_action;
   assign rsp_if.last_event     = rsp_word_ff.last_event;

endmodule
`default_nettype wire

### rtl/button_multi_click_detector_core.sv
`default_nettype none
// Path: an accepted tick word goes into the tick queue, its result word into the
// result register. Throughput: one word per cycle while the result side is ready;
// per-pin state is written back on each pop, so same-pin words may run back to back.
// Reset: synchronous; clears the tick queue, the result stage, all pin state
// (idle, released, no event) and loads the register defaults 300/1000/500/0/0.
// ----------------------------------------------------------------------------
// button_multi_click_detector_core
// Debounced button decoder: press, release, long press, hold repeat and
// click bursts per pin, plus the channel toggle each pin's role asks for.
// ----------------------------------------------------------------------------
module button_multi_click_detector_core (
   input  wire logic        clock,
   input  wire logic        reset,
   bmcd_req_if.sink         req_if,
   bmcd_rsp_if.source       rsp_if,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [14:0] csr_wdata
);

   bmcd_pkg::cfg_type       cfg_ff, cfg_in;
   logic                    q_valid;
   logic                    q_pop;
   bmcd_pkg::q_entry_type   q_data;

   // Register file; writes to unused indexes fall through.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bmcd_pkg::CSR_SHORT_GAP:     cfg_in.short_gap_ms   = csr_wdata;
            bmcd_pkg::CSR_LONG_PRESS:    cfg_in.long_press_ms  = csr_wdata;
            bmcd_pkg::CSR_HOLD_REPEAT:   cfg_in.hold_repeat_ms = csr_wdata;
            bmcd_pkg::CSR_CHILD_LOCK:    cfg_in.child_lock     = csr_wdata[0];
            bmcd_pkg::CSR_INSTANT_TOUCH: cfg_in.instant_touch  = csr_wdata[0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_gap_ms   <= 15'd300;
         cfg_ff.long_press_ms  <= 15'd1000;
         cfg_ff.hold_repeat_ms <= 15'd500;
         cfg_ff.child_lock     <= 1'b0;
         cfg_ff.instant_touch  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: takes words, folds polarity, drops pins beyond the pin count,
   // and holds up to two words so the back end can stall on its own.
   bmcd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .q_pop   (q_pop),
      .q_valid (q_valid),
      .q_data  (q_data)
   );

   // Back: per-pin debounce and phase machine, then the result register.
   bmcd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_data  (q_data),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

endmodule
`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button multi-click detector core. Tick words
// are driven on a valid/ready channel with random gaps, each accepted tick is
// run through a cycle-free model of the per-pin debounce and phase logic, and
// every result word is checked field by field, in order, against that model.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CLK_HALF            = 10;
   localparam int RESET_CYCLES        = 12;
   localparam int PIPE_LAT            = 2;
   localparam int QUIET_LIMIT         = 3000;  // cycles with no word moving
   localparam int BACKPRESSURE_CYCLES = 250;
   localparam int MAX_REPORTS         = 50;
   localparam int IDLE_PCT            = 17;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [14:0] csr_wdata;

   bmcd_req_if tick_ch ();
   bmcd_rsp_if result_ch ();

   button_multi_click_detector_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (tick_ch),
      .rsp_if    (result_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   // --------------------------------------------------------------------------
   // Bench-side copy of the block: current register values and per-pin state.
   // --------------------------------------------------------------------------
   bmcd_pkg::cfg_type       cfg_now;
   bmcd_pkg::pin_state_type pin_model [bmcd_pkg::NUM_PINS];
   bmcd_pkg::rsp_word_type  pending_results [$];   // expected result words, oldest first

   int n_fail        = 0;
   int ticks_sent    = 0;
   int quiet_cycles  = 0;
   int holdoff_count = 0;   // bumped by a test, one hold-off per bump
   int holdoff_seen  = 0;   // receiver's copy of holdoff_count
   int holdoff_left  = 0;
   bit steady        = 1'b0; // both sides skip their random idles while set

   function automatic bmcd_pkg::cfg_type make_cfg(input int gap, input int long_ms,
                                                  input int hold_ms, input bit lock,
                                                  input bit instant);
      bmcd_pkg::cfg_type c;
      c.short_gap_ms   = 15'(gap);
      c.long_press_ms  = 15'(long_ms);
      c.hold_repeat_ms = 15'(hold_ms);
      c.child_lock     = lock;
      c.instant_touch  = instant;
      return c;
   endfunction

   function automatic logic [15:0] add_sat16(input logic [15:0] a, input logic [9:0] b);
      logic [16:0] s;
      s = a + b;
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   // One tick for one pin: debounce, advance the phase machine, build the word.
   function automatic bmcd_pkg::rsp_word_type decode_tick(input logic [4:0] pin,
                                                          input logic raw,
                                                          input logic inv,
                                                          input logic [1:0] role,
                                                          input logic [9:0] dt);
      bmcd_pkg::pin_state_type st;
      bmcd_pkg::rsp_word_type  res;
      logic          level;
      logic          down;
      logic          quiet;
      logic [1:0]    press_act;
      logic [11:0]   deb_sum;
      st        = pin_model[pin];
      level     = raw ^ inv;
      quiet     = cfg_now.child_lock;
      press_act = (role == bmcd_pkg::ROLE_TOGGLE_ALL) ? bmcd_pkg::ACT_ALL :
                  (role == bmcd_pkg::ROLE_SCRIPT)     ? bmcd_pkg::ACT_NONE :
                                                        bmcd_pkg::ACT_FIRST;
      res.pin_echo       = pin;
      res.notice         = bmcd_pkg::NOTICE_NONE;
      res.channel_action = bmcd_pkg::ACT_NONE;

      if (st.phase != bmcd_pkg::PH_IDLE)
         st.phase_time = add_sat16(st.phase_time, dt);

      // a new level is taken only after 50 ms of disagreement
      if (level == st.dlevel) begin
         st.deb_time = '0;
      end else if (st.deb_time >= bmcd_pkg::DEBOUNCE_MS) begin
         st.dlevel   = level;
         st.deb_time = '0;
      end else begin
         deb_sum     = st.deb_time + dt;
         st.deb_time = (deb_sum > bmcd_pkg::DEB_MAX) ? bmcd_pkg::DEB_MAX : deb_sum[10:0];
      end
      down = !st.dlevel;

      case (st.phase)
         bmcd_pkg::PH_IDLE: begin
            if (down) begin
               st.evt = bmcd_pkg::EVT_DOWN;
               if (!quiet) begin
                  res.notice = bmcd_pkg::NOTICE_PRESS;
                  if (cfg_now.instant_touch)
                     res.channel_action = press_act;
               end
               st.phase_time = '0;
               st.clicks     = 3'd1;
               st.phase      = bmcd_pkg::PH_PRESSED;
            end else begin
               st.evt = bmcd_pkg::EVT_NONE;
            end
         end
         bmcd_pkg::PH_PRESSED: begin
            if (!down) begin
               st.evt = bmcd_pkg::EVT_UP;
               if (!quiet) res.notice = bmcd_pkg::NOTICE_RELEASE;
               st.phase_time = '0;
               st.phase      = bmcd_pkg::PH_RELEASED;
            end else if (st.phase_time > cfg_now.long_press_ms) begin
               st.evt = bmcd_pkg::EVT_LONG;
               if (!quiet) res.notice = bmcd_pkg::NOTICE_HOLD_START;
               st.phase = bmcd_pkg::PH_LONG;
            end
         end
         bmcd_pkg::PH_RELEASED: begin
            if (down && st.clicks < bmcd_pkg::MAX_CLICKS) begin
               st.evt        = bmcd_pkg::EVT_DOWN;
               st.clicks     = st.clicks + 3'd1;
               st.phase_time = '0;
               st.phase      = bmcd_pkg::PH_AGAIN;
            end else if (st.phase_time > cfg_now.short_gap_ms ||
                         st.clicks >= bmcd_pkg::MAX_CLICKS) begin
               // burst over: report it by click count
               st.evt = bmcd_pkg::EVT_CLICK_OFS + 4'(st.clicks);
               if (!quiet) begin
                  if (st.clicks == 3'd2 && role == bmcd_pkg::ROLE_TOGGLE_ALL) begin
                     // silent toggle-all on double click
                     res.channel_action = bmcd_pkg::ACT_ALL;
                  end else begin
                     res.notice = bmcd_pkg::NOTICE_CLICK_OFS + 4'(st.clicks);
                     if (st.clicks == 3'd1 && !cfg_now.instant_touch)
                        res.channel_action = press_act;
                     if (st.clicks == 3'd2 && role == bmcd_pkg::ROLE_NORMAL)
                        res.channel_action = bmcd_pkg::ACT_SECOND;
                  end
               end
               st.phase = bmcd_pkg::PH_IDLE;
            end
         end
         bmcd_pkg::PH_AGAIN: begin
            if (!down) begin
               st.evt = bmcd_pkg::EVT_UP;
               if (!quiet) res.notice = bmcd_pkg::NOTICE_RELEASE;
               // a press held too long ends the burst without a click notice
               if (st.phase_time < cfg_now.short_gap_ms) begin
                  st.phase_time = '0;
                  st.phase      = bmcd_pkg::PH_RELEASED;
               end else begin
                  st.phase = bmcd_pkg::PH_IDLE;
               end
            end
         end
         bmcd_pkg::PH_LONG: begin
            if (down) begin
               st.evt       = bmcd_pkg::EVT_HOLD;
               st.hold_time = add_sat16(st.hold_time, dt);
               // hold_time survives a release, so leftovers carry over
               if (st.hold_time > cfg_now.hold_repeat_ms) begin
                  if (!quiet) res.notice = bmcd_pkg::NOTICE_HOLD_REPEAT;
                  st.hold_time = '0;
               end
            end else begin
               st.evt = bmcd_pkg::EVT_UP;
               if (!quiet) res.notice = bmcd_pkg::NOTICE_RELEASE;
               st.phase = bmcd_pkg::PH_IDLE;
            end
         end
         default: ;
      endcase

      res.last_event = st.evt;
      pin_model[pin] = st;
      return res;
   endfunction

   // --------------------------------------------------------------------------
   // Tick sender. Valid stays up after an accepted word; the next call either
   // reuses it or drops it for a random idle.
   // --------------------------------------------------------------------------
   task automatic send_tick(input logic [4:0] pin, input logic raw, input logic inv,
                            input logic [1:0] role, input logic [9:0] dt);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         tick_ch.valid <= 1'b0;
         @(posedge clock);
      end
      tick_ch.valid        <= 1'b1;
      tick_ch.pin_number   <= pin;
      tick_ch.raw_level    <= raw;
      tick_ch.invert_level <= inv;
      tick_ch.button_role  <= role;
      tick_ch.elapsed_ms   <= dt;
      do @(posedge clock); while (!tick_ch.ready);
      pending_results.push_back(decode_tick(pin, raw, inv, role, dt));
      ticks_sent++;
   endtask

   task automatic noise_tick(input logic [4:0] pin);
      send_tick(pin, 1'($urandom), 1'($urandom), 2'($urandom),
                10'($urandom_range(1023, 0)));
   endtask

   // n ticks at one level; down means pressed after polarity correction
   task automatic hold_level(input logic [4:0] pin, input logic [1:0] role, input logic inv,
                             input bit down, input logic [9:0] dt, input int n);
      repeat (n) send_tick(pin, down ? inv : !inv, inv, role, dt);
   endtask

   // with 60 ms ticks a level change lands on the second tick
   task automatic click(input logic [4:0] pin, input logic [1:0] role, input logic inv);
      hold_level(pin, role, inv, 1'b1, 10'd60, 2);
      hold_level(pin, role, inv, 1'b0, 10'd60, 2);
   endtask

   // hold a level for about ms milliseconds, with stray ticks on other pins
   task automatic hold_for_ms(input logic [4:0] pin, input logic [1:0] role, input logic inv,
                              input bit down, input int ms, input int dt_lo, input int dt_hi);
      int         spent;
      logic [9:0] dt;
      logic [4:0] other;
      spent = 0;
      while (spent < ms) begin
         dt    = 10'($urandom_range(dt_hi, dt_lo));
         other = 5'($urandom_range(31, 1));
         if ($urandom_range(99) < 8)
            noise_tick(pin ^ other);
         send_tick(pin, down ? inv : !inv, inv, role, dt);
         spent += dt;
      end
   endtask

   // stop feeding ticks and let every expected word come back
   task automatic drain_results();
      tick_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 2) @(posedge clock);
   endtask

   // writes all eight indexes; the spare ones and the upper flag bits get junk
   task automatic write_csrs(input bmcd_pkg::cfg_type c);
      logic [2:0]  which;
      logic [14:0] value;
      drain_results();
      which = bmcd_pkg::CSR_SHORT_GAP;
      repeat (8) begin
         value = 15'($urandom);
         case (which)
            bmcd_pkg::CSR_SHORT_GAP:     value    = c.short_gap_ms;
            bmcd_pkg::CSR_LONG_PRESS:    value    = c.long_press_ms;
            bmcd_pkg::CSR_HOLD_REPEAT:   value    = c.hold_repeat_ms;
            bmcd_pkg::CSR_CHILD_LOCK:    value[0] = c.child_lock;
            bmcd_pkg::CSR_INSTANT_TOUCH: value[0] = c.instant_touch;
            default: ;
         endcase
         csr_wr_en <= 1'b1;
         csr_index <= which;
         csr_wdata <= value;
         @(posedge clock);
         which = which + 3'd1;
      end
      csr_wr_en <= 1'b0;
      cfg_now = c;
   endtask

   // mostly well-formed click bursts and long presses, some bounce and noise
   task automatic random_gesture();
      logic [4:0] pin;
      logic [1:0] role;
      logic       inv;
      int         kind;
      int         long_ms;
      pin  = 5'($urandom);
      role = 2'($urandom);
      inv  = 1'($urandom);
      kind = $urandom_range(99);
      if (kind < 15) begin
         noise_tick(pin);
      end else if (kind < 22) begin
         // bounce shorter than the debounce window
         hold_for_ms(pin, role, inv, 1'b1, $urandom_range(45, 1), 1, 20);
      end else if (kind < 80) begin
         repeat ($urandom_range(6, 1)) begin
            hold_for_ms(pin, role, inv, 1'b1, $urandom_range(300, 60), 5, 70);
            hold_for_ms(pin, role, inv, 1'b0, $urandom_range(300, 60), 5, 70);
         end
         hold_for_ms(pin, role, inv, 1'b0, cfg_now.short_gap_ms + 100, 100, 1023);
      end else begin
         long_ms = (cfg_now.long_press_ms <= 3000) ?
                   cfg_now.long_press_ms + $urandom_range(2500, 0) : $urandom_range(4000, 500);
         hold_for_ms(pin, role, inv, 1'b1, long_ms, 20, 150);
         hold_for_ms(pin, role, inv, 1'b0, $urandom_range(400, 60), 5, 70);
      end
   endtask

   task automatic run_random(input bmcd_pkg::cfg_type c, input int n);
      int target;
      write_csrs(c);
      target = ticks_sent + n;
      while (ticks_sent < target) random_gesture();
   endtask

   // --------------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------------

   // lowest and highest pin, elapsed 0 and 1023, both polarities, every role
   task automatic test_field_extremes();
      send_tick(5'd31, 1'b1, 1'b0, bmcd_pkg::ROLE_SMART_LED, 10'd0);
      send_tick(5'd0, 1'b0, 1'b1, bmcd_pkg::ROLE_NORMAL, 10'd1023);
      send_tick(5'd31, 1'b0, 1'b0, bmcd_pkg::ROLE_TOGGLE_ALL, 10'd1023);
      send_tick(5'd31, 1'b1, 1'b1, bmcd_pkg::ROLE_SCRIPT, 10'd0);          // press taken here
      hold_level(5'd31, bmcd_pkg::ROLE_SCRIPT, 1'b1, 1'b0, 10'd1023, 3);   // hold start, then release
   endtask

   // double click: toggle-all is silent, smart led has no action, normal toggles second
   task automatic test_double_click_roles();
      logic [1:0] role;
      for (int i = 1; i <= 3; i++) begin
         role = (i == 1) ? bmcd_pkg::ROLE_NORMAL :
                (i == 2) ? bmcd_pkg::ROLE_TOGGLE_ALL : bmcd_pkg::ROLE_SMART_LED;
         click(5'(i), role, 1'b0);
         click(5'(i), role, 1'b0);
         hold_level(5'(i), role, 1'b0, 1'b0, 10'd1023, 1);
      end
   endtask

   // five clicks end the burst on the next tick whatever the gap
   task automatic test_burst_limit();
      repeat (bmcd_pkg::MAX_CLICKS) click(5'd4, bmcd_pkg::ROLE_NORMAL, 1'b1);
      hold_level(5'd4, bmcd_pkg::ROLE_NORMAL, 1'b1, 1'b1, 10'd0, 1);
   endtask

   // leftover hold time from one long press fires a repeat early in the next
   task automatic test_hold_carry();
      hold_level(5'd7, bmcd_pkg::ROLE_NORMAL, 1'b0, 1'b1, 10'd60, 2);
      hold_level(5'd7, bmcd_pkg::ROLE_NORMAL, 1'b0, 1'b1, 10'd200, 11);
      hold_level(5'd7, bmcd_pkg::ROLE_NORMAL, 1'b0, 1'b0, 10'd50, 1);
      hold_level(5'd7, bmcd_pkg::ROLE_NORMAL, 1'b0, 1'b0, 10'd0, 1);
      hold_level(5'd7, bmcd_pkg::ROLE_NORMAL, 1'b0, 1'b1, 10'd60, 2);
      hold_level(5'd7, bmcd_pkg::ROLE_NORMAL, 1'b0, 1'b1, 10'd200, 7);
      hold_level(5'd7, bmcd_pkg::ROLE_NORMAL, 1'b0, 1'b0, 10'd60, 2);
   endtask

   // a second press held past 65.5 s must saturate, not wrap below the gap
   task automatic test_time_saturation();
      click(5'd8, bmcd_pkg::ROLE_NORMAL, 1'b0);
      hold_level(5'd8, bmcd_pkg::ROLE_NORMAL, 1'b0, 1'b1, 10'd60, 2);
      hold_level(5'd8, bmcd_pkg::ROLE_NORMAL, 1'b0, 1'b1, 10'd1023, 64);
      hold_level(5'd8, bmcd_pkg::ROLE_NORMAL, 1'b0, 1'b0, 10'd100, 1);
      hold_level(5'd8, bmcd_pkg::ROLE_NORMAL, 1'b0, 1'b0, 10'd0, 1);
      hold_level(5'd8, bmcd_pkg::ROLE_NORMAL, 1'b0, 1'b0, 10'd1023, 1);
   endtask

   // script-only pin under instant touch: press noticed, no action; toggle-all acts on press
   task automatic test_instant_script();
      write_csrs(make_cfg(300, 1000, 500, 1'b0, 1'b1));
      click(5'd5, bmcd_pkg::ROLE_SCRIPT, 1'b0);
      hold_level(5'd5, bmcd_pkg::ROLE_SCRIPT, 1'b0, 1'b0, 10'd1023, 1);
      click(5'd6, bmcd_pkg::ROLE_TOGGLE_ALL, 1'b1);
      hold_level(5'd6, bmcd_pkg::ROLE_TOGGLE_ALL, 1'b1, 1'b0, 10'd1023, 1);
   endtask

   // lock on: phases still run, nothing is reported or toggled
   task automatic test_child_lock();
      write_csrs(make_cfg(300, 1000, 500, 1'b1, 1'b1));
      click(5'd9, bmcd_pkg::ROLE_TOGGLE_ALL, 1'b0);
      click(5'd9, bmcd_pkg::ROLE_TOGGLE_ALL, 1'b0);
      hold_level(5'd9, bmcd_pkg::ROLE_TOGGLE_ALL, 1'b0, 1'b0, 10'd1023, 1);
      hold_level(5'd10, bmcd_pkg::ROLE_NORMAL, 1'b0, 1'b1, 10'd60, 2);
      hold_level(5'd10, bmcd_pkg::ROLE_NORMAL, 1'b0, 1'b1, 10'd300, 6);
      hold_level(5'd10, bmcd_pkg::ROLE_NORMAL, 1'b0, 1'b0, 10'd60, 2);
   endtask

   // receiver stops for a long stretch; the sender keeps offering until it stalls
   task automatic test_output_backpressure();
      int target;
      write_csrs(make_cfg(300, 1000, 500, 1'b0, 1'b0));
      holdoff_count++;
      target = ticks_sent + 60;
      while (ticks_sent < target) random_gesture();
   endtask

   task automatic test_random_traffic();
      // back-to-back stretch first, then random idles on both sides
      steady = 1'b1;
      run_random(make_cfg(300, 1000, 500, 1'b0, 1'b0), 150);
      steady = 1'b0;
      run_random(make_cfg(300, 1000, 500, 1'b0, 1'b0), 150);
      run_random(make_cfg(150, 400, 100, 1'b0, 1'b1), 200);
      run_random(make_cfg(300, 1000, 500, 1'b1, 1'b0), 120);
      run_random(make_cfg(0, 0, 0, 1'b0, 1'b0), 120);
      run_random(make_cfg(25500, 25500, 25500, 1'b0, 1'b1), 120);
      run_random(make_cfg($urandom_range(2000, 20), $urandom_range(3000, 100),
                          $urandom_range(1500, 10), $urandom_range(1, 0),
                          $urandom_range(1, 0)), 190);
   endtask

   // --------------------------------------------------------------------------
   // Result side: random ready with a requested hold-off, in-order checking
   // --------------------------------------------------------------------------
   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         n_fail++;
         if (n_fail <= MAX_REPORTS)
            $error("%s: expected %0d, got %0d", field, want, got);
      end
   endtask

   always @(posedge clock) begin : result_check
      bmcd_pkg::rsp_word_type want;
      if (!reset && result_ch.valid && result_ch.ready) begin
         if (pending_results.size() == 0) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS)
               $error("result word with none expected, pin %0d", result_ch.pin_echo);
         end else begin
            want = pending_results.pop_front();
            compare_field("pin_echo", want.pin_echo, result_ch.pin_echo);
            compare_field("notice", want.notice, result_ch.notice);
            compare_field("channel_action", want.channel_action, result_ch.channel_action);
            compare_field("last_event", want.last_event, result_ch.last_event);
         end
      end
      if (holdoff_seen != holdoff_count) begin
         holdoff_seen = holdoff_count;
         holdoff_left = BACKPRESSURE_CYCLES;
      end
      if (reset) begin
         result_ch.ready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left--;
         result_ch.ready <= 1'b0;
      end else begin
         result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // watchdog: too long with no word moving on either side means a hang
   always @(posedge clock) begin
      if (reset || (tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // --------------------------------------------------------------------------
   // Sequence
   // --------------------------------------------------------------------------
   initial begin
      reset                <= 1'b1;
      tick_ch.valid        <= 1'b0;
      tick_ch.pin_number   <= '0;
      tick_ch.raw_level    <= 1'b0;
      tick_ch.invert_level <= 1'b0;
      tick_ch.button_role  <= bmcd_pkg::ROLE_NORMAL;
      tick_ch.elapsed_ms   <= '0;
      csr_wr_en            <= 1'b0;
      csr_index            <= bmcd_pkg::CSR_SHORT_GAP;
      csr_wdata            <= '0;

      // model matches the block after reset: defaults, all pins idle and up
      cfg_now = make_cfg(300, 1000, 500, 1'b0, 1'b0);
      for (int i = 0; i < bmcd_pkg::NUM_PINS; i++)
         pin_model[i] = '{phase: bmcd_pkg::PH_IDLE, dlevel: 1'b1, deb_time: '0,
                          phase_time: '0, hold_time: '0, clicks: '0,
                          evt: bmcd_pkg::EVT_NONE};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_double_click_roles();
      test_burst_limit();
      test_hold_carry();
      test_time_saturation();
      test_instant_script();
      test_child_lock();
      test_output_backpressure();
      test_random_traffic();

      drain_results();
      if (n_fail == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
